[hw/rtl/lcps_pkg.sv]
`timescale 1ns / 1ps

package lcps_pkg;

    // Defaults for the top-level parameters.
    localparam int LAYER_COUNT_DEF      = 8;
    localparam int MAX_LAYER_WIDTH_DEF  = 800;
    localparam int MAX_LAYER_HEIGHT_DEF = 600;
    localparam int CURSOR_ROWS_DEF      = 11;
    localparam int CURSOR_COLS_DEF      = 6;

    // Lane numbers are compared at this width; it covers up to sixteen layers.
    localparam int LANE_IDX_W = 4;

    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 10;
    localparam int SLOT_W   = 3;
    localparam int OFFSET_W = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_X         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_Y         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE_PIXELS = 2'd2;

    typedef struct packed {
        logic                      cmd;
        logic [SLOT_W-1:0]         layer_slot;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [SIZE_W-1:0]         layer_width;
        logic [SIZE_W-1:0]         layer_height;
        logic                      layer_enable;
    } in_item_t;

    typedef struct packed {
        logic                base_source;
        logic [SLOT_W-1:0]   source_layer;
        logic [OFFSET_W-1:0] buffer_offset;
        logic                cursor_hit;
        logic                keep_top_byte;
    } out_item_t;

    // Position of the queried pixel inside one layer, with that layer's width.
    typedef struct packed {
        logic [SIZE_W-1:0] cx;
        logic [SIZE_W-1:0] cy;
        logic [SIZE_W-1:0] w;
    } lane_t;

    // The chosen layer for one pixel; all zero for the background.
    typedef struct packed {
        logic              src;
        logic [SLOT_W-1:0] layer;
        logic [SIZE_W-1:0] cx;
        logic [SIZE_W-1:0] cy;
        logic [SIZE_W-1:0] w;
    } sel_t;

    typedef struct packed {
        logic hit;
        logic keep;
    } cursor_t;

    // Arrow bitmap: bit c of row r is column c.
    function automatic logic [31:0] arrow_row(input logic [4:0] row);
        logic [31:0] bits;
        case (row)
            5'd0:    bits = 32'h01;
            5'd1:    bits = 32'h03;
            5'd2:    bits = 32'h07;
            5'd3:    bits = 32'h0F;
            5'd4:    bits = 32'h1F;
            5'd5:    bits = 32'h0F;
            5'd6:    bits = 32'h0F;
            5'd7:    bits = 32'h0F;
            5'd8:    bits = 32'h1D;
            5'd9:    bits = 32'h18;
            5'd10:   bits = 32'h30;
            default: bits = 32'h00;
        endcase
        return bits;
    endfunction

endpackage

[hw/rtl/lcps_layer_table.sv]
`timescale 1ns / 1ps

module lcps_layer_table #(
    parameter int LAYER_COUNT      = lcps_pkg::LAYER_COUNT_DEF,
    parameter int MAX_LAYER_WIDTH  = lcps_pkg::MAX_LAYER_WIDTH_DEF,
    parameter int MAX_LAYER_HEIGHT = lcps_pkg::MAX_LAYER_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lcps_pkg::in_item_t                  item,
    input  logic                                wr_en,
    output logic [LAYER_COUNT-1:0]              hit,
    output lcps_pkg::lane_t [LAYER_COUNT-1:0]   lane
);

    logic [lcps_pkg::SIZE_W-1:0] w_next;
    logic [lcps_pkg::SIZE_W-1:0] h_next;

    always_comb
    begin
        w_next = (32'(item.layer_width) > MAX_LAYER_WIDTH)
               ? lcps_pkg::SIZE_W'(MAX_LAYER_WIDTH) : item.layer_width;
        h_next = (32'(item.layer_height) > MAX_LAYER_HEIGHT)
               ? lcps_pkg::SIZE_W'(MAX_LAYER_HEIGHT) : item.layer_height;
    end

    for (genvar i = 0; i < LAYER_COUNT; i++)
    begin : g_lane
        logic signed [lcps_pkg::COORD_W-1:0] x_reg;
        logic signed [lcps_pkg::COORD_W-1:0] y_reg;
        logic [lcps_pkg::SIZE_W-1:0]         w_reg;
        logic [lcps_pkg::SIZE_W-1:0]         h_reg;
        logic                                en_reg;
        logic [lcps_pkg::COORD_W:0]          cx;
        logic [lcps_pkg::COORD_W:0]          cy;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                x_reg  <= '0;
                y_reg  <= '0;
                w_reg  <= '0;
                h_reg  <= '0;
                en_reg <= 1'b0;
            end
            else if (wr_en && lcps_pkg::LANE_IDX_W'(item.layer_slot)
                              == lcps_pkg::LANE_IDX_W'(i))
            begin
                x_reg  <= item.pos_x;
                y_reg  <= item.pos_y;
                w_reg  <= w_next;
                h_reg  <= h_next;
                en_reg <= item.layer_enable;
            end
        end

        // One sign bit more than the coordinates, so the difference never wraps.
        always_comb
        begin
            cx = {item.pos_x[lcps_pkg::COORD_W-1], item.pos_x}
               - {x_reg[lcps_pkg::COORD_W-1], x_reg};
            cy = {item.pos_y[lcps_pkg::COORD_W-1], item.pos_y}
               - {y_reg[lcps_pkg::COORD_W-1], y_reg};
            hit[i] = en_reg
                  && !item.pos_x[lcps_pkg::COORD_W-1]
                  && !item.pos_y[lcps_pkg::COORD_W-1]
                  && !cx[lcps_pkg::COORD_W] && !cy[lcps_pkg::COORD_W]
                  && (cx[lcps_pkg::COORD_W-1:0] < lcps_pkg::COORD_W'(w_reg))
                  && (cy[lcps_pkg::COORD_W-1:0] < lcps_pkg::COORD_W'(h_reg));
            // On a hit both differences are below the size, so they fit its width.
            lane[i].cx = cx[lcps_pkg::SIZE_W-1:0];
            lane[i].cy = cy[lcps_pkg::SIZE_W-1:0];
            lane[i].w  = w_reg;
        end
    end

endmodule

[hw/rtl/lcps_cursor_match.sv]
`timescale 1ns / 1ps

module lcps_cursor_match #(
    parameter int CURSOR_ROWS = lcps_pkg::CURSOR_ROWS_DEF,
    parameter int CURSOR_COLS = lcps_pkg::CURSOR_COLS_DEF
) (
    input  lcps_pkg::in_item_t                 item,
    input  logic [lcps_pkg::COORD_W-1:0]       cursor_x,
    input  logic [lcps_pkg::COORD_W-1:0]       cursor_y,
    input  logic                               four_byte_pixels,
    output lcps_pkg::cursor_t                  cursor
);

    logic [lcps_pkg::COORD_W:0] dx;
    logic [lcps_pkg::COORD_W:0] dy;
    logic [31:0]                row_bits;
    logic                       in_box;

    always_comb
    begin
        // A query pixel with a negative coordinate is off screen; it is excluded below.
        dx = {1'b0, item.pos_x} - {1'b0, cursor_x};
        dy = {1'b0, item.pos_y} - {1'b0, cursor_y};
        row_bits = lcps_pkg::arrow_row(dy[4:0]);
        in_box = !item.pos_x[lcps_pkg::COORD_W-1]
              && !item.pos_y[lcps_pkg::COORD_W-1]
              && !dx[lcps_pkg::COORD_W] && !dy[lcps_pkg::COORD_W]
              && (32'(dx[lcps_pkg::COORD_W-1:0]) < CURSOR_COLS)
              && (32'(dy[lcps_pkg::COORD_W-1:0]) < CURSOR_ROWS)
              && (dx[lcps_pkg::COORD_W-1:0] < lcps_pkg::COORD_W'(32))
              && (dy[lcps_pkg::COORD_W-1:0] < lcps_pkg::COORD_W'(32));
        cursor.hit  = in_box && row_bits[dx[4:0]];
        cursor.keep = cursor.hit && !four_byte_pixels;
    end

endmodule

[hw/rtl/lcps_layer_select.sv]
`timescale 1ns / 1ps

module lcps_layer_select #(
    parameter int LAYER_COUNT = lcps_pkg::LAYER_COUNT_DEF
) (
    input  logic [LAYER_COUNT-1:0]              hit,
    input  lcps_pkg::lane_t [LAYER_COUNT-1:0]   lane,
    output lcps_pkg::sel_t                      sel
);

    // Higher slots lie on top, so a later hit overrides an earlier one.
    always_comb
    begin
        sel = '0;
        for (int i = 0; i < LAYER_COUNT; i++)
        begin
            if (hit[i])
            begin
                sel.src   = 1'b1;
                sel.layer = lcps_pkg::SLOT_W'(i);
                sel.cx    = lane[i].cx;
                sel.cy    = lane[i].cy;
                sel.w     = lane[i].w;
            end
        end
    end

endmodule

[hw/rtl/layer_compositor_pixel_select.sv]
`timescale 1ns / 1ps

// Per-pixel layer compositor. A load command (cmd 0) writes one entry of the
// layer table and gives no result; a query (cmd 1) gives one result naming the
// topmost enabled layer that covers the pixel, the word offset inside that
// layer's buffer, and whether the arrow cursor sets the pixel. One item is
// taken in every cycle while in_stall is low; a query's result passes through
// four register stages: input, per-layer window match, top-layer selection,
// and the offset multiply-add into the output register. A load changes the
// table as it leaves the input stage, so every later item sees it.
// Configuration writes are always ready and take effect at once; they should
// only be made while no query is in flight.
module layer_compositor_pixel_select #(
    parameter int LAYER_COUNT      = lcps_pkg::LAYER_COUNT_DEF,
    parameter int MAX_LAYER_WIDTH  = lcps_pkg::MAX_LAYER_WIDTH_DEF,
    parameter int MAX_LAYER_HEIGHT = lcps_pkg::MAX_LAYER_HEIGHT_DEF,
    parameter int CURSOR_ROWS      = lcps_pkg::CURSOR_ROWS_DEF,
    parameter int CURSOR_COLS      = lcps_pkg::CURSOR_COLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lcps_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lcps_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [lcps_pkg::COORD_W-1:0] cursor_x_reg;
    logic [lcps_pkg::COORD_W-1:0] cursor_y_reg;
    logic                         four_byte_reg;

    logic                 s1_valid_reg;
    lcps_pkg::in_item_t   s1_item_reg;

    logic                                s2_valid_reg;
    logic [LAYER_COUNT-1:0]              s2_hit_reg;
    lcps_pkg::lane_t [LAYER_COUNT-1:0]   s2_lane_reg;
    lcps_pkg::cursor_t                   s2_cur_reg;

    logic                 s3_valid_reg;
    lcps_pkg::sel_t       s3_sel_reg;
    lcps_pkg::cursor_t    s3_cur_reg;

    logic                 out_valid_reg;
    lcps_pkg::out_item_t  out_reg;

    logic out_ready;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;
    logic table_wr;

    logic [LAYER_COUNT-1:0]              hit_next;
    lcps_pkg::lane_t [LAYER_COUNT-1:0]   lane_next;
    lcps_pkg::cursor_t                   cur_next;
    lcps_pkg::sel_t                      sel_next;
    logic [2*lcps_pkg::SIZE_W:0]         sum_next;
    lcps_pkg::out_item_t                 out_next;

    // A stage takes new contents when it is empty or its contents move on.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign table_wr  = s1_valid_reg && (s1_item_reg.cmd == lcps_pkg::CMD_LOAD) && s2_ready;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            four_byte_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lcps_pkg::CFG_CURSOR_X:         cursor_x_reg  <= cfg_data;
                lcps_pkg::CFG_CURSOR_Y:         cursor_y_reg  <= cfg_data;
                lcps_pkg::CFG_FOUR_BYTE_PIXELS: four_byte_reg <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    lcps_layer_table #(
        .LAYER_COUNT      (LAYER_COUNT),
        .MAX_LAYER_WIDTH  (MAX_LAYER_WIDTH),
        .MAX_LAYER_HEIGHT (MAX_LAYER_HEIGHT)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (s1_item_reg),
        .wr_en (table_wr),
        .hit   (hit_next),
        .lane  (lane_next)
    );

    lcps_cursor_match #(
        .CURSOR_ROWS (CURSOR_ROWS),
        .CURSOR_COLS (CURSOR_COLS)
    ) u_cursor (
        .item             (s1_item_reg),
        .cursor_x         (cursor_x_reg),
        .cursor_y         (cursor_y_reg),
        .four_byte_pixels (four_byte_reg),
        .cursor           (cur_next)
    );

    lcps_layer_select #(
        .LAYER_COUNT (LAYER_COUNT)
    ) u_select (
        .hit  (s2_hit_reg),
        .lane (s2_lane_reg),
        .sel  (sel_next)
    );

    always_comb
    begin
        sum_next = (2*lcps_pkg::SIZE_W+1)'(s3_sel_reg.cy) * (2*lcps_pkg::SIZE_W+1)'(s3_sel_reg.w)
                 + (2*lcps_pkg::SIZE_W+1)'(s3_sel_reg.cx);
        out_next.base_source   = s3_sel_reg.src;
        out_next.source_layer  = s3_sel_reg.layer;
        out_next.buffer_offset = sum_next[lcps_pkg::OFFSET_W-1:0];
        out_next.cursor_hit    = s3_cur_reg.hit;
        out_next.keep_top_byte = s3_cur_reg.keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            // Loads end in the first stage.
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg && (s1_item_reg.cmd == lcps_pkg::CMD_QUERY);
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_item_reg <= in_data;
        end
        if (s2_ready)
        begin
            s2_hit_reg  <= hit_next;
            s2_lane_reg <= lane_next;
            s2_cur_reg  <= cur_next;
        end
        if (s3_ready)
        begin
            s3_sel_reg <= sel_next;
            s3_cur_reg <= s2_cur_reg;
        end
        if (out_ready)
        begin
            out_reg <= out_next;
        end
    end

    a_stall_needs_full_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled while the first stage is empty");

    a_load_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_item_reg.cmd == lcps_pkg::CMD_LOAD) && s2_ready
        |=> !s2_valid_reg)
        else $error("a layer load went on down the pipeline");

    a_background_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.base_source
        |-> (out_reg.source_layer == '0) && (out_reg.buffer_offset == '0))
        else $error("background result carries a layer or an offset");

    a_keep_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.keep_top_byte |-> out_reg.cursor_hit)
        else $error("top byte kept without a cursor hit");

endmodule
